// ----- hdl/serial_command_line_parser_core_defines.svh -----
// Assertion helpers for the command line parser.
`ifndef SERIAL_COMMAND_LINE_PARSER_CORE_DEFINES_SVH
`define SERIAL_COMMAND_LINE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SCLP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCLP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sclp_pkg.sv -----
package sclp_pkg;

    localparam int CMD_FIELD_LEN = 8;
    localparam int LINE_BUF_LEN  = 80;

    localparam int CNT_W  = $clog2(CMD_FIELD_LEN);
    localparam int LINE_W = $clog2(LINE_BUF_LEN);

    localparam int TEXT_W  = 56;
    localparam int LEN_W   = 3;
    localparam int VALUE_W = 32;
    localparam int MAG_W   = 32;
    localparam int TEXT_CHARS = TEXT_W / 8;

    localparam logic [1:0] PH_WAIT   = 2'd0;
    localparam logic [1:0] PH_CMD    = 2'd1;
    localparam logic [1:0] PH_VAL    = 2'd2;
    localparam logic [1:0] PH_CLOSED = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [MAG_W-1:0]   MAG_CAP   = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [TEXT_W-1:0]         text;
        logic [LEN_W-1:0]          length;
        logic signed [VALUE_W-1:0] value;
    } t_cmd;

endpackage

// ----- hdl/sclp_ifs.sv -----
interface sclp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface sclp_cmd_if import sclp_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [TEXT_W-1:0]         cmd_text;
    logic [LEN_W-1:0]          cmd_length;
    logic signed [VALUE_W-1:0] cmd_value;

    modport source (output valid, output cmd_text, output cmd_length, output cmd_value,
                    input ready);
    modport sink (input valid, input cmd_text, input cmd_length, input cmd_value,
                  output ready);
endinterface

// ----- hdl/serial_command_line_parser_core.sv -----
// Serial command line parser, one byte per beat.
// Throughput: one input beat per cycle, sustained, while the output is taken.
// A command record is valid after the line-ending beat, or the beat at the line
// buffer limit, passes the input register, then the result register.
// Reset: synchronous, active low; clears both stage valids and the line state.
`include "serial_command_line_parser_core_defines.svh"

module serial_command_line_parser_core import sclp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sclp_byte_if.sink  i_byte,
    sclp_cmd_if.source o_cmd
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       advance;
    logic       emit;
    logic       slot_free;
    t_cmd       parsed;
    t_cmd       held;

    sclp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_byte.valid),
        .i_byte    (i_byte.in_byte),
        .i_advance (advance),
        .o_ready   (i_byte.ready),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    sclp_line_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .i_slot_free (slot_free),
        .o_advance   (advance),
        .o_emit      (emit),
        .o_cmd       (parsed)
    );

    sclp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (emit),
        .i_cmd       (parsed),
        .i_ready     (o_cmd.ready),
        .o_slot_free (slot_free),
        .o_valid     (o_cmd.valid),
        .o_cmd       (held)
    );

    assign o_cmd.cmd_text   = held.text;
    assign o_cmd.cmd_length = held.length;
    assign o_cmd.cmd_value  = held.value;

    `SCLP_ASSERT_IMP(a_emit_has_slot, i_clk, i_rst_n, emit, slot_free && advance, "record emitted without free slot")
    `SCLP_ASSERT_NXT(a_in_holds, i_clk, i_rst_n, in_valid && !advance, in_valid && $stable(in_byte), "stalled input beat lost")
    `SCLP_ASSERT_IMP(a_text_nonempty, i_clk, i_rst_n, o_cmd.valid && (o_cmd.cmd_length != 3'd0), o_cmd.cmd_text[7:0] != 8'd0, "command length without text")

endmodule

// ----- hdl/sclp_in_stage.sv -----
module sclp_in_stage import sclp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_advance,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ----- hdl/sclp_line_parser.sv -----
module sclp_line_parser import sclp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_slot_free,
    output logic       o_advance,
    output logic       o_emit,
    output t_cmd       o_cmd
);

    logic [1:0]        r_phase, n_phase;
    logic [LINE_W-1:0] r_line_cnt, n_line_cnt;
    logic [TEXT_W-1:0] r_word_buf, n_word_buf;
    logic [CNT_W-1:0]  r_word_cnt, n_word_cnt;
    logic [CNT_W-1:0]  r_num_cnt, n_num_cnt;
    logic              r_minus, n_minus;
    logic              r_digits, n_digits;
    logic              r_closed, n_closed;
    logic [MAG_W-1:0]  r_mag, n_mag;

    logic              eol;
    logic              at_limit;
    logic              emit_req;
    logic [1:0]        eff_phase;
    logic              is_digit;
    logic [MAG_W+3:0]  mag_next;
    logic [7:0]        word_cnt_x;

    assign eol        = (i_byte == CH_CR) || (i_byte == CH_LF);
    assign at_limit   = r_line_cnt >= LINE_W'(LINE_BUF_LEN - 2);
    assign emit_req   = i_valid && (r_phase != PH_WAIT) && (eol || at_limit);
    assign o_advance  = i_valid && (!emit_req || i_slot_free);
    assign o_emit     = emit_req && i_slot_free;
    assign eff_phase  = (r_phase == PH_WAIT) ? PH_CMD : r_phase;
    assign is_digit   = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign word_cnt_x = 8'(r_word_cnt);
    assign mag_next   = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) + (MAG_W + 4)'(i_byte[3:0]);

    always_comb begin
        o_cmd.text   = r_word_buf;
        o_cmd.length = (word_cnt_x > 8'd7) ? 3'd7 : 3'(r_word_cnt);
        if (!r_digits) begin
            o_cmd.value = '0;
        end else if (r_minus) begin
            o_cmd.value = VALUE_W'(0) - r_mag;
        end else begin
            o_cmd.value = r_mag[MAG_W-1] ? VALUE_MAX : r_mag;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_line_cnt = r_line_cnt;
        n_word_buf = r_word_buf;
        n_word_cnt = r_word_cnt;
        n_num_cnt  = r_num_cnt;
        n_minus    = r_minus;
        n_digits   = r_digits;
        n_closed   = r_closed;
        n_mag      = r_mag;
        if (r_phase == PH_WAIT && eol) begin
            n_phase = PH_WAIT;
        end else if (emit_req) begin
            n_phase    = PH_WAIT;
            n_line_cnt = '0;
            n_word_buf = '0;
            n_word_cnt = '0;
            n_num_cnt  = '0;
            n_minus    = 1'b0;
            n_digits   = 1'b0;
            n_closed   = 1'b0;
            n_mag      = '0;
        end else begin
            n_line_cnt = (r_phase == PH_WAIT) ? LINE_W'(1) : r_line_cnt + 1'b1;
            case (eff_phase)
                PH_CMD: begin
                    n_phase = PH_CMD;
                    if (i_byte == CH_NUL) begin
                        n_phase = PH_CLOSED;
                    end else if (i_byte == CH_SP) begin
                        n_phase = PH_VAL;
                    end else begin
                        for (int i = 0; i < TEXT_CHARS; i++) begin
                            if (word_cnt_x == 8'(i)) begin
                                n_word_buf[8*i +: 8] = i_byte;
                            end
                        end
                        n_word_cnt = r_word_cnt + 1'b1;
                        if (r_word_cnt == CNT_W'(CMD_FIELD_LEN - 2)) begin
                            n_phase = PH_VAL;
                        end
                    end
                end
                PH_VAL: begin
                    if (i_byte == CH_NUL) begin
                        n_phase = PH_CLOSED;
                    end else if (is_digit || i_byte == CH_MINUS) begin
                        n_num_cnt = r_num_cnt + 1'b1;
                        if (!r_closed) begin
                            if (i_byte == CH_MINUS) begin
                                if (r_num_cnt == '0) begin
                                    n_minus = 1'b1;
                                end else begin
                                    n_closed = 1'b1;
                                end
                            end else begin
                                n_mag    = (mag_next > (MAG_W + 4)'(MAG_CAP)) ?
                                           MAG_CAP : mag_next[MAG_W-1:0];
                                n_digits = 1'b1;
                            end
                        end
                        if (r_num_cnt == CNT_W'(CMD_FIELD_LEN - 2)) begin
                            n_phase = PH_CLOSED;
                        end
                    end else if (i_byte != CH_SP) begin
                        n_phase = PH_CLOSED;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT;
            r_line_cnt <= '0;
            r_word_buf <= '0;
            r_word_cnt <= '0;
            r_num_cnt  <= '0;
            r_minus    <= 1'b0;
            r_digits   <= 1'b0;
            r_closed   <= 1'b0;
            r_mag      <= '0;
        end else if (o_advance) begin
            r_phase    <= n_phase;
            r_line_cnt <= n_line_cnt;
            r_word_buf <= n_word_buf;
            r_word_cnt <= n_word_cnt;
            r_num_cnt  <= n_num_cnt;
            r_minus    <= n_minus;
            r_digits   <= n_digits;
            r_closed   <= n_closed;
            r_mag      <= n_mag;
        end
    end

endmodule

// ----- hdl/sclp_out_stage.sv -----
module sclp_out_stage import sclp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_cmd i_cmd,
    input  logic i_ready,
    output logic o_slot_free,
    output logic o_valid,
    output t_cmd o_cmd
);

    logic r_valid;
    t_cmd r_cmd;

    assign o_slot_free = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd <= i_cmd;
        end
    end

endmodule
